// ----- design/assert_macros.svh -----
// Assertion macros for the port checker of the dose map rasterizer.
// No dependencies; every macro uses the clock and active-low reset given to it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMR_ASSERT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DMR_ASSERT_NEXT(label, clk, rstn, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ----- design/dmr_pkg.sv -----
// Shared constants for the dose map rasterizer: map geometry, opcodes, status codes,
// register indexes and divider sizing. No dependencies.
package dmr_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(MAP_DEPTH);

    localparam int CELL_W     = 32;
    localparam int POS_W      = 24;
    localparam int POS_NUM_W  = POS_W + 1;
    localparam int DIV_CNT_W  = 5;
    localparam int POS_ITERS  = POS_NUM_W;
    localparam int NORM_ITERS = 16;
    localparam int LEVEL_W    = 17;

    localparam logic [1:0] OP_DEPOSIT = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    localparam logic [1:0] STAT_DEPOSITED = 2'd0;
    localparam logic [1:0] STAT_DROPPED   = 2'd1;
    localparam logic [1:0] STAT_READ      = 2'd2;
    localparam logic [1:0] STAT_CLEARED   = 2'd3;

    localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PIXEL_STEP = 2'd2;

    localparam logic [7:0]  RST_MAP_WIDTH  = 8'd128;
    localparam logic [7:0]  RST_MAP_HEIGHT = 8'd128;
    localparam logic [15:0] RST_PIXEL_STEP = 16'd256;

    localparam logic [15:0]        DOSE_ONE   = 16'd256;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(65536);

endpackage

// ----- design/dmr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dmr_ram #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/dmr_div.sv -----
// Restoring divider, one quotient bit per cycle, with a preloadable remainder.
// Depends on dmr_pkg for operand widths.
module dmr_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [dmr_pkg::CELL_W-1:0]     rem_init,
    input  logic [dmr_pkg::POS_NUM_W-1:0]  numer,
    input  logic [dmr_pkg::DIV_CNT_W-1:0]  iters,
    input  logic [dmr_pkg::CELL_W-1:0]     divisor,
    output logic                           done,
    output logic [dmr_pkg::POS_NUM_W-1:0]  quot
);

    logic                           run_reg,  run_next;
    logic                           done_reg, done_next;
    logic [dmr_pkg::CELL_W-1:0]     rem_reg,  rem_next;
    logic [dmr_pkg::CELL_W-1:0]     den_reg,  den_next;
    logic [dmr_pkg::POS_NUM_W-1:0]  num_reg,  num_next;
    logic [dmr_pkg::POS_NUM_W-1:0]  quot_reg, quot_next;
    logic [dmr_pkg::DIV_CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [dmr_pkg::CELL_W:0]       trial;
    logic [dmr_pkg::CELL_W:0]       diff;
    logic                           fits;

    // The remainder always stays below the divisor, so the difference fits in CELL_W bits.
    assign trial = {rem_reg, num_reg[dmr_pkg::POS_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (start) begin
            run_next  = 1'b1;
            rem_next  = rem_init;
            den_next  = divisor;
            num_next  = numer;
            quot_next = '0;
            cnt_next  = iters;
        end else if (run_reg) begin
            rem_next  = fits ? diff[dmr_pkg::CELL_W-1:0] : trial[dmr_pkg::CELL_W-1:0];
            num_next  = {num_reg[dmr_pkg::POS_NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[dmr_pkg::POS_NUM_W-2:0], fits};
            cnt_next  = cnt_reg - dmr_pkg::DIV_CNT_W'(1);
            if (cnt_reg == dmr_pkg::DIV_CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- design/dose_map_rasterizer.sv -----
// Top level of the dose map rasterizer: sequencer, configuration registers and output stage.
// Depends on dmr_pkg, dmr_ram and dmr_div.
//
//   Channel  Direction  Handshake            Beat contents
//   s_       in         s_valid / s_ready    operation, x_pos, y_pos, dose, read_col, read_row
//   m_       out        m_valid / m_ready    status, level, saturated
//   apb      in         psel/penable/pready  map_width, map_height, pixel_step at 0x0, 0x4, 0x8
//
// One beat is worked on at a time. For a deposit, two 25-step dividers split x and y by twice
// the pixel step, then the cell is read, updated and written back; a dropped deposit answers
// once the division is done, with no RAM access. A read is answered through a 16-step division
// of the cell by the peak, directly with full scale when the cell is at the peak, and without
// reading the cell outside the map or with a zero peak. A clear sweeps all 16384 cells, one per
// cycle, and then answers. After reset the same clearing pass runs before s_ready first rises.
// A finished result waits in the output register, so a stalled m_ready only blocks the
// next beat once that beat has its own result ready.
module dose_map_rasterizer (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [3:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_operation,
    input  logic signed [23:0]                   s_x_pos,
    input  logic signed [23:0]                   s_y_pos,
    input  logic signed [15:0]                   s_dose,
    input  logic [6:0]                           s_read_col,
    input  logic [6:0]                           s_read_row,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_status,
    output logic [dmr_pkg::LEVEL_W-1:0]          m_level,
    output logic                                 m_saturated
);

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_INIT = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_RD   = 8'b0000_1000,
        S_MOD  = 8'b0001_0000,
        S_NORM = 8'b0010_0000,
        S_CLR  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    localparam int AW = dmr_pkg::ADDR_W;
    localparam int CW = dmr_pkg::CELL_W;
    localparam int NW = dmr_pkg::POS_NUM_W;
    localparam int LW = dmr_pkg::LEVEL_W;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0]  map_width_reg,  map_width_next;
    logic [7:0]  map_height_reg, map_height_next;
    logic [15:0] pixel_step_reg, pixel_step_next;

    // Running peak over all cells.
    logic [CW-1:0] peak_reg, peak_next;

    // Per-beat working registers.
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          is_read_reg, is_read_next;
    logic          x_neg_reg, x_neg_next;
    logic          y_neg_reg, y_neg_next;
    logic [15:0]   add_reg, add_next;

    // Pending result, then the output register.
    logic [1:0]    res_status_reg, res_status_next;
    logic [LW-1:0] res_level_reg,  res_level_next;
    logic          res_sat_reg,    res_sat_next;
    logic          m_valid_reg,    m_valid_next;
    logic [1:0]    m_status_reg,   m_status_next;
    logic [LW-1:0] m_level_reg,    m_level_next;
    logic          m_sat_reg,      m_sat_next;

    // APB.
    logic       cfg_write;
    logic [1:0] cfg_index;

    // Datapath helpers.
    logic          s_accept;
    logic [7:0]    eff_width;
    logic [7:0]    eff_height;
    logic [15:0]   step_eff;
    logic [23:0]   x_mag;
    logic [23:0]   y_mag;
    logic [NW-1:0] x_num;
    logic [NW-1:0] y_num;
    logic [CW-1:0] pos_den;
    logic          drop;
    logic [CW:0]   sum;

    // RAM ports.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [CW-1:0] ram_wdata;
    logic          ram_re;
    logic [CW-1:0] ram_rdata;

    // Divider ports. The x unit is also used to normalize a cell by the peak.
    logic                         xd_start;
    logic [CW-1:0]                xd_rem;
    logic [NW-1:0]                xd_num;
    logic [dmr_pkg::DIV_CNT_W-1:0] xd_iters;
    logic [CW-1:0]                xd_den;
    logic                         xd_done;
    logic [NW-1:0]                xd_quot;
    logic                         yd_start;
    logic                         yd_done;
    logic [NW-1:0]                yd_quot;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_comb begin
        unique case (cfg_index)
            dmr_pkg::REG_MAP_WIDTH:  prdata = {24'd0, map_width_reg};
            dmr_pkg::REG_MAP_HEIGHT: prdata = {24'd0, map_height_reg};
            dmr_pkg::REG_PIXEL_STEP: prdata = {16'd0, pixel_step_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_comb begin
        map_width_next  = map_width_reg;
        map_height_next = map_height_reg;
        pixel_step_next = pixel_step_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                dmr_pkg::REG_MAP_WIDTH:  map_width_next  = pwdata[7:0];
                dmr_pkg::REG_MAP_HEIGHT: map_height_next = pwdata[7:0];
                dmr_pkg::REG_PIXEL_STEP: pixel_step_next = pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Width and height saturate at the store's geometry; a zero step acts as one.
    assign eff_width  = (32'(map_width_reg) > dmr_pkg::MAX_WIDTH) ?
                        8'(dmr_pkg::MAX_WIDTH) : map_width_reg;
    assign eff_height = (32'(map_height_reg) > dmr_pkg::MAX_HEIGHT) ?
                        8'(dmr_pkg::MAX_HEIGHT) : map_height_reg;
    assign step_eff   = (pixel_step_reg == 16'd0) ? 16'd1 : pixel_step_reg;

    // Rounding half away from zero: (2*|pos| + step) / (2*step), sign applied afterwards.
    assign x_mag   = s_x_pos[23] ? 24'($unsigned(-s_x_pos)) : 24'($unsigned(s_x_pos));
    assign y_mag   = s_y_pos[23] ? 24'($unsigned(-s_y_pos)) : 24'($unsigned(s_y_pos));
    assign x_num   = {x_mag, 1'b0} + NW'(step_eff);
    assign y_num   = {y_mag, 1'b0} + NW'(step_eff);
    assign pos_den = {15'd0, step_eff, 1'b0};

    // A negative coordinate that rounds to zero is still pixel zero.
    assign drop = (x_neg_reg && xd_quot != '0) || (y_neg_reg && yd_quot != '0) ||
                  (xd_quot >= NW'(eff_width)) || (yd_quot >= NW'(eff_height));

    assign sum = {1'b0, ram_rdata} + (CW + 1)'(add_reg);

    assign s_ready  = (state_reg == S_IDLE);
    assign s_accept = s_valid && s_ready;
    assign yd_start = s_accept && (s_operation == dmr_pkg::OP_DEPOSIT);

    always_comb begin
        state_next      = state_reg;
        peak_next       = peak_reg;
        addr_next       = addr_reg;
        clr_cnt_next    = clr_cnt_reg;
        is_read_next    = is_read_reg;
        x_neg_next      = x_neg_reg;
        y_neg_next      = y_neg_reg;
        add_next        = add_reg;
        res_status_next = res_status_reg;
        res_level_next  = res_level_reg;
        res_sat_next    = res_sat_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_level_next    = m_level_reg;
        m_sat_next      = m_sat_reg;

        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = '0;
        ram_re    = 1'b0;

        xd_start = 1'b0;
        xd_rem   = '0;
        xd_num   = x_num;
        xd_iters = dmr_pkg::DIV_CNT_W'(dmr_pkg::POS_ITERS);
        xd_den   = pos_den;

        unique case (state_reg)
            S_INIT, S_CLR: begin
                // Clearing pass: one cell per cycle.
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(dmr_pkg::MAP_DEPTH - 1)) begin
                    peak_next = '0;
                    if (state_reg == S_CLR) begin
                        res_status_next = dmr_pkg::STAT_CLEARED;
                        res_level_next  = '0;
                        res_sat_next    = 1'b0;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    res_level_next = '0;
                    res_sat_next   = 1'b0;
                    unique case (s_operation)
                        dmr_pkg::OP_DEPOSIT: begin
                            xd_start     = 1'b1;
                            x_neg_next   = s_x_pos[23];
                            y_neg_next   = s_y_pos[23];
                            add_next     = (s_dose == 16'sd0 || s_dose[15]) ?
                                           dmr_pkg::DOSE_ONE : 16'($unsigned(s_dose));
                            is_read_next = 1'b0;
                            state_next   = S_DIV;
                        end
                        dmr_pkg::OP_READ: begin
                            res_status_next = dmr_pkg::STAT_READ;
                            is_read_next    = 1'b1;
                            addr_next       = AW'(32'(s_read_row) * dmr_pkg::MAX_WIDTH +
                                                  32'(s_read_col));
                            if (8'(s_read_col) < eff_width && 8'(s_read_row) < eff_height &&
                                peak_reg != '0) begin
                                state_next = S_RD;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        dmr_pkg::OP_CLEAR: begin
                            clr_cnt_next = '0;
                            state_next   = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                // Both coordinate dividers start together and run the same count.
                if (xd_done && yd_done) begin
                    addr_next = AW'(32'(yd_quot) * dmr_pkg::MAX_WIDTH + 32'(xd_quot));
                    if (drop) begin
                        res_status_next = dmr_pkg::STAT_DROPPED;
                        state_next      = S_DONE;
                    end else begin
                        res_status_next = dmr_pkg::STAT_DEPOSITED;
                        state_next      = S_RD;
                    end
                end
            end
            S_RD: begin
                ram_re     = 1'b1;
                state_next = S_MOD;
            end
            S_MOD: begin
                if (!is_read_reg) begin
                    // Read-modify-write; the next beat cannot start before this write lands.
                    ram_we       = 1'b1;
                    ram_wdata    = sum[CW] ? '1 : sum[CW-1:0];
                    res_sat_next = sum[CW];
                    if (ram_wdata > peak_reg) begin
                        peak_next = ram_wdata;
                    end
                    state_next = S_DONE;
                end else if (ram_rdata >= peak_reg) begin
                    res_level_next = dmr_pkg::FULL_LEVEL;
                    state_next     = S_DONE;
                end else begin
                    xd_start   = 1'b1;
                    xd_rem     = ram_rdata;
                    xd_num     = '0;
                    xd_iters   = dmr_pkg::DIV_CNT_W'(dmr_pkg::NORM_ITERS);
                    xd_den     = peak_reg;
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                if (xd_done) begin
                    res_level_next = LW'(xd_quot[dmr_pkg::NORM_ITERS-1:0]);
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_level_next  = res_level_reg;
                    m_sat_next    = res_sat_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            clr_cnt_reg    <= '0;
            peak_reg       <= '0;
            m_valid_reg    <= 1'b0;
            map_width_reg  <= dmr_pkg::RST_MAP_WIDTH;
            map_height_reg <= dmr_pkg::RST_MAP_HEIGHT;
            pixel_step_reg <= dmr_pkg::RST_PIXEL_STEP;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            peak_reg       <= peak_next;
            m_valid_reg    <= m_valid_next;
            map_width_reg  <= map_width_next;
            map_height_reg <= map_height_next;
            pixel_step_reg <= pixel_step_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        is_read_reg    <= is_read_next;
        x_neg_reg      <= x_neg_next;
        y_neg_reg      <= y_neg_next;
        add_reg        <= add_next;
        res_status_reg <= res_status_next;
        res_level_reg  <= res_level_next;
        res_sat_reg    <= res_sat_next;
        m_status_reg   <= m_status_next;
        m_level_reg    <= m_level_next;
        m_sat_reg      <= m_sat_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_level     = m_level_reg;
    assign m_saturated = m_sat_reg;

    dmr_ram #(
        .ADDR_W(AW),
        .DATA_W(CW)
    ) u_dose_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    dmr_div u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (xd_start),
        .rem_init (xd_rem),
        .numer    (xd_num),
        .iters    (xd_iters),
        .divisor  (xd_den),
        .done     (xd_done),
        .quot     (xd_quot)
    );

    dmr_div u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (yd_start),
        .rem_init ('0),
        .numer    (y_num),
        .iters    (dmr_pkg::DIV_CNT_W'(dmr_pkg::POS_ITERS)),
        .divisor  (pos_den),
        .done     (yd_done),
        .quot     (yd_quot)
    );

endmodule

// ----- design/dmr_checker.sv -----
// Port-level checker for the dose map rasterizer, bound to the top level.
// Depends on dmr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmr_port_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [1:0]                    s_operation,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_status,
    input logic [dmr_pkg::LEVEL_W-1:0]   m_level,
    input logic                          m_saturated
);

    // A stalled result beat holds.
    `DMR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_level) && $stable(m_saturated),
        "result beat changed while stalled")

    // Only reads carry a level.
    `DMR_ASSERT(a_level_zero, aclk, aresetn, m_valid && m_status != dmr_pkg::STAT_READ,
        m_level == '0, "nonzero level on a non-read result")

    // A read level never exceeds full scale.
    `DMR_ASSERT(a_level_max, aclk, aresetn, m_valid && m_status == dmr_pkg::STAT_READ,
        m_level <= dmr_pkg::FULL_LEVEL, "read level above full scale")

    // Saturation is only reported on deposits.
    `DMR_ASSERT(a_sat_dep, aclk, aresetn, m_valid && m_saturated,
        m_status == dmr_pkg::STAT_DEPOSITED, "saturation flag on a non-deposit result")

    // A clear starts a sweep, so no beat is taken in the next cycle.
    `DMR_ASSERT_NEXT(a_clr_busy, aclk, aresetn,
        s_valid && s_ready && s_operation == dmr_pkg::OP_CLEAR, !s_ready,
        "input taken right after a clear")

endmodule

bind dose_map_rasterizer dmr_port_checker u_dmr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_operation (s_operation),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_level     (m_level),
    .m_saturated (m_saturated)
);
